@@ design/assert_macros.svh @@
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define S2F_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked check that also holds during reset.
`define S2F_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/s2f_pkg.sv @@
package s2f_pkg;

    localparam logic [7:0] NL_BYTE  = 8'h0A;
    localparam logic [7:0] TAB_BYTE = 8'h09;

    localparam logic [3:0] SEQ_TABS_RST    = 4'd9;
    localparam logic [7:0] HEADER_MARK_RST = 8'h40;
    localparam logic [7:0] RECORD_MARK_RST = 8'h3E;

    localparam logic [3:0] TAB_MAX = 4'd15;

    // Configuration register indexes
    localparam logic [1:0] REG_SEQ_TABS    = 2'd0;
    localparam logic [1:0] REG_HEADER_MARK = 2'd1;
    localparam logic [1:0] REG_RECORD_MARK = 2'd2;

    localparam int MAX_RES = 3;

    typedef enum logic [2:0] {
        PH_LINE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_NAME   = 3'd2,
        PH_TABS   = 3'd3,
        PH_SEQ    = 3'd4,
        PH_REST   = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       stream_end;
    } t_result;

    typedef struct packed {
        t_result [MAX_RES-1:0] res;
        logic [1:0]            cnt;
    } t_group;

    typedef struct packed {
        t_phase     phase;
        logic [3:0] tab_count;
        logic       record_seen;
    } t_parse_status;

    typedef struct packed {
        logic [3:0] seq_field_tabs;
        logic [7:0] header_mark;
        logic [7:0] record_mark;
    } t_cfg;

    // Tab count after one more tab, saturating
    function automatic logic [3:0] tab_inc(input logic [3:0] tc);
        tab_inc = (tc < TAB_MAX) ? tc + 4'd1 : TAB_MAX;
    endfunction

endpackage

@@ design/s2f_if.sv @@
interface s2f_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface s2f_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       stream_end;

    modport source (output valid, output out_byte, output has_byte,
                    output run_last, output stream_end, input ready);
    modport sink   (input valid, input out_byte, input has_byte,
                    input run_last, input stream_end, output ready);
endinterface

interface s2f_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/s2f_parse.sv @@
module s2f_parse (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [7:0]              i_byte,
    input  logic                    i_last,
    input  s2f_pkg::t_cfg           i_cfg,
    output logic                    o_load,
    output s2f_pkg::t_group         o_group,
    output s2f_pkg::t_parse_status  o_status
);
    import s2f_pkg::*;

    t_phase     r_phase, n_phase;
    logic [3:0] r_tab, n_tab;
    logic       r_seen, n_seen;
    logic [3:0] w_tab_next;
    logic       w_skip_hdr;

    assign w_skip_hdr = !r_seen && (i_byte == i_cfg.header_mark);
    // Line start restarts the count, so the name tab always counts as one
    assign w_tab_next = (r_phase == PH_LINE) ? 4'd1 : tab_inc(r_tab);

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_tab   = r_tab;
        n_seen  = r_seen;
        unique case (r_phase)
            PH_LINE: begin
                if (w_skip_hdr) begin
                    n_phase = (i_byte == NL_BYTE) ? PH_LINE : PH_HEADER;
                end else begin
                    n_seen = 1'b1;
                    n_tab  = 4'd0;
                    if (i_byte == NL_BYTE) begin
                        n_phase = PH_LINE;
                    end else if (i_byte == TAB_BYTE) begin
                        n_tab   = w_tab_next;
                        n_phase = (w_tab_next >= i_cfg.seq_field_tabs) ? PH_SEQ : PH_TABS;
                    end else begin
                        n_phase = PH_NAME;
                    end
                end
            end
            PH_NAME, PH_TABS: begin
                if (i_byte == NL_BYTE) begin
                    n_phase = PH_LINE;
                end else if (i_byte == TAB_BYTE) begin
                    n_tab   = w_tab_next;
                    n_phase = (w_tab_next >= i_cfg.seq_field_tabs) ? PH_SEQ : PH_TABS;
                end
            end
            PH_SEQ: begin
                if (i_byte == NL_BYTE) begin
                    n_phase = PH_LINE;
                end else if (i_byte == TAB_BYTE) begin
                    n_phase = PH_REST;
                end
            end
            default: begin
                if (i_byte == NL_BYTE) begin
                    n_phase = PH_LINE;
                end
            end
        endcase
        if (i_last) begin
            n_phase = PH_LINE;
            n_tab   = 4'd0;
            n_seen  = 1'b0;
        end
    end

    // Result group for this byte
    always_comb begin
        logic [1:0] k;
        k       = 2'd0;
        o_group = '0;
        unique case (r_phase)
            PH_LINE: begin
                if (!w_skip_hdr) begin
                    if (r_seen) begin
                        o_group.res[k] = '{NL_BYTE, 1'b1, 1'b0, 1'b0};
                        k = k + 2'd1;
                    end
                    o_group.res[k] = '{i_cfg.record_mark, 1'b1, 1'b0, 1'b0};
                    k = k + 2'd1;
                    if (i_byte == TAB_BYTE) begin
                        o_group.res[k] = '{NL_BYTE, 1'b1, 1'b0, 1'b0};
                        k = k + 2'd1;
                    end else if (i_byte != NL_BYTE) begin
                        o_group.res[k] = '{i_byte, 1'b1, 1'b0, 1'b0};
                        k = k + 2'd1;
                    end
                end
            end
            PH_NAME: begin
                if (i_byte == TAB_BYTE) begin
                    o_group.res[k] = '{NL_BYTE, 1'b1, 1'b0, 1'b0};
                    k = k + 2'd1;
                end else if (i_byte != NL_BYTE) begin
                    o_group.res[k] = '{i_byte, 1'b1, 1'b0, 1'b0};
                    k = k + 2'd1;
                end
            end
            PH_SEQ: begin
                if (i_byte != NL_BYTE && i_byte != TAB_BYTE) begin
                    o_group.res[k] = '{i_byte, 1'b1, 1'b0, 1'b0};
                    k = k + 2'd1;
                end
            end
            default: begin
            end
        endcase
        // Bare end marker when the final byte yields nothing
        if (i_last && k == 2'd0) begin
            k = 2'd1;
        end
        if (k != 2'd0) begin
            o_group.res[k - 2'd1].run_last   = 1'b1;
            o_group.res[k - 2'd1].stream_end = i_last;
        end
        o_group.cnt = k;
    end

    assign o_load   = i_accept && (o_group.cnt != 2'd0);
    assign o_status = '{r_phase, r_tab, r_seen};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LINE;
            r_tab   <= 4'd0;
            r_seen  <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_tab   <= n_tab;
            r_seen  <= n_seen;
        end
    end

endmodule

@@ design/s2f_emit.sv @@
module s2f_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  s2f_pkg::t_group i_group,
    output logic            o_can_take,
    s2f_out_if.source       o_out
);
    import s2f_pkg::*;

    t_result [MAX_RES-1:0] r_slot;
    logic [1:0]            r_cnt;
    logic                  w_fire;

    assign w_fire     = o_out.valid && o_out.ready;
    // Take a new group when empty or when the last pending item leaves now
    assign o_can_take = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_out.ready);

    assign o_out.valid      = (r_cnt != 2'd0);
    assign o_out.out_byte   = r_slot[0].out_byte;
    assign o_out.has_byte   = r_slot[0].has_byte;
    assign o_out.run_last   = r_slot[0].run_last;
    assign o_out.stream_end = r_slot[0].stream_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_group.cnt;
        end else if (w_fire) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_group.res;
        end else if (w_fire) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

endmodule

@@ design/sam_to_fasta_stream_core.sv @@
// Channel  Dir  Payload                                   Accept
// i_in     in   in_byte[7:0], in_last                     valid && ready
// o_out    out  out_byte[7:0], has_byte, run_last,        valid && ready
//               stream_end
// i_cfg    in   index[1:0], data[7:0]                     valid && ready (ready held high)
//
// Each byte is parsed in the cycle it is accepted and its up to three
// result items land in a three-slot output buffer the next cycle.
// Throughput is one byte per cycle while each byte yields at most one item
// and the output is ready; a record start yields up to three items and holds
// input while the buffer drains, one item per cycle while the output is ready.
// Reset is synchronous, active low; no clearing pass is needed.
// Output stalls back up into input ready only through the output buffer.
`include "assert_macros.svh"

module sam_to_fasta_stream_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    s2f_in_if.sink    i_in,
    s2f_out_if.source o_out,
    s2f_cfg_if.sink   i_cfg
);
    import s2f_pkg::*;

    t_cfg          r_cfg;
    logic          w_accept;
    logic          w_can_take;
    logic          w_load;
    t_group        w_group;
    t_parse_status w_status;

    // Register writes are always taken; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seq_field_tabs <= SEQ_TABS_RST;
            r_cfg.header_mark    <= HEADER_MARK_RST;
            r_cfg.record_mark    <= RECORD_MARK_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_SEQ_TABS:    r_cfg.seq_field_tabs <= i_cfg.data[3:0];
                REG_HEADER_MARK: r_cfg.header_mark    <= i_cfg.data;
                REG_RECORD_MARK: r_cfg.record_mark    <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Advance the parser only when the output buffer can hold the group
    assign i_in.ready = w_can_take;
    assign w_accept   = i_in.valid && i_in.ready;

    s2f_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_in.in_byte),
        .i_last   (i_in.in_last),
        .i_cfg    (r_cfg),
        .o_load   (w_load),
        .o_group  (w_group),
        .o_status (w_status)
    );

    s2f_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_group    (w_group),
        .o_can_take (w_can_take),
        .o_out      (o_out)
    );

    // A new byte only enters while the buffer is empty or draining its last item
    `S2F_ASSERT(a_accept_drain, i_clk, i_rst_n, w_accept |-> (!o_out.valid || o_out.ready), "byte accepted over a stalled buffer")
    // Final byte of a file returns the parser to its reset state
    `S2F_ASSERT(a_last_clears, i_clk, i_rst_n, (w_accept && i_in.in_last) |=> (w_status.phase == PH_LINE && !w_status.record_seen && w_status.tab_count == 4'd0), "parser state not cleared after end of file")
    // End of file is always the last item of its byte
    `S2F_ASSERT(a_end_is_run_last, i_clk, i_rst_n, (o_out.valid && o_out.stream_end) |-> o_out.run_last, "stream end without run last")
    // Nothing is pending in the buffer while reset is held
    `S2F_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out.valid, "output valid right after reset")

endmodule

@@ tb/sam_to_fasta_stream_core_tb.sv @@
`timescale 1ns / 1ps

module sam_to_fasta_stream_core_tb;
    import s2f_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and the three channels
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always #1 i_clk = ~i_clk;

    s2f_in_if  in_ch ();
    s2f_out_if out_ch ();
    s2f_cfg_if cfg_ch ();

    sam_to_fasta_stream_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Bare end marker: no data, closes both the byte and the file
    localparam t_result END_MARK = '{out_byte: 8'h00, has_byte: 1'b0,
                                     run_last: 1'b1, stream_end: 1'b1};

    // ------------------------------------------------------------------
    // Converter shadow: register copy, parse state and the FASTA items
    // still owed by the block
    // ------------------------------------------------------------------
    t_cfg       cfg_s;
    t_phase     ps_phase;
    logic [3:0] ps_tabs;
    logic       ps_seen;

    t_result    pred_res [3];
    int         pred_n;
    t_result    fasta_q [$];

    int errors     = 0;
    int checked    = 0;
    int items_sent = 0;
    int files_sent = 0;
    int settings   = 0;

    function automatic void emit(input logic [7:0] b);
        pred_res[pred_n] = '{out_byte: b, has_byte: 1'b1, run_last: 1'b0, stream_end: 1'b0};
        pred_n++;
    endfunction

    // One more tab after the name: saturate the count, then decide whether
    // the sequence field has been reached
    function automatic void take_tab();
        if (ps_tabs != 4'd15)
            ps_tabs = ps_tabs + 4'd1;
        ps_phase = (ps_tabs >= cfg_s.seq_field_tabs) ? PH_SEQ : PH_TABS;
    endfunction

    function automatic void clear_parse();
        ps_phase = PH_LINE;
        ps_tabs  = 4'd0;
        ps_seen  = 1'b0;
    endfunction

    // Work out the FASTA items that one SAM byte causes; fills pred_res
    function automatic int convert_byte(input logic [7:0] b, input logic last);
        pred_n = 0;
        case (ps_phase)
            PH_LINE: begin
                if (!ps_seen && b == cfg_s.header_mark) begin
                    // header lines only count before the first record
                    ps_phase = (b == NL_BYTE) ? PH_LINE : PH_HEADER;
                end else begin
                    // lazy separator: newline only ahead of a later record
                    if (ps_seen)
                        emit(NL_BYTE);
                    emit(cfg_s.record_mark);
                    ps_seen = 1'b1;
                    ps_tabs = 4'd0;
                    if (b == NL_BYTE) begin
                        ps_phase = PH_LINE;
                    end else if (b == TAB_BYTE) begin
                        emit(NL_BYTE);
                        take_tab();
                    end else begin
                        emit(b);
                        ps_phase = PH_NAME;
                    end
                end
            end
            PH_HEADER: begin
                if (b == NL_BYTE)
                    ps_phase = PH_LINE;
            end
            PH_NAME: begin
                if (b == NL_BYTE) begin
                    ps_phase = PH_LINE;
                end else if (b == TAB_BYTE) begin
                    emit(NL_BYTE);
                    take_tab();
                end else begin
                    emit(b);
                end
            end
            PH_TABS: begin
                if (b == NL_BYTE)
                    ps_phase = PH_LINE;
                else if (b == TAB_BYTE)
                    take_tab();
            end
            PH_SEQ: begin
                if (b == NL_BYTE)
                    ps_phase = PH_LINE;
                else if (b == TAB_BYTE)
                    ps_phase = PH_REST;
                else
                    emit(b);
            end
            default: begin
                if (b == NL_BYTE)
                    ps_phase = PH_LINE;
            end
        endcase

        // a silent final byte still closes the file with a bare marker
        if (last && pred_n == 0) begin
            pred_res[0] = END_MARK;
            pred_n = 1;
        end
        if (pred_n > 0) begin
            pred_res[pred_n-1].run_last = 1'b1;
            if (last)
                pred_res[pred_n-1].stream_end = 1'b1;
        end
        if (last)
            clear_parse();
        return pred_n;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Idle length: mostly none, sometimes short, rarely long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 0;
        else if (r < 9)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 20);
    endfunction

    // Field content: any byte but the two separators
    function automatic logic [7:0] text_byte();
        logic [7:0] v;
        do
            v = 8'($urandom_range(0, 255));
        while (v == NL_BYTE || v == TAB_BYTE);
        return v;
    endfunction

    // Noise: separators are heavily weighted
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0, 1:    return NL_BYTE;
            2:       return TAB_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] base_byte();
        logic [7:0] v;
        case ($urandom_range(0, 5))
            0:       v = "A";
            1:       v = "C";
            2:       v = "G";
            3:       v = "T";
            4:       v = "N";
            default: v = text_byte();
        endcase
        return v;
    endfunction

    function automatic t_result data_res(input logic [7:0] b, input logic rl, input logic se);
        return '{out_byte: b, has_byte: 1'b1, run_last: rl, stream_end: se};
    endfunction

    // ------------------------------------------------------------------
    // Directed stimulus table
    // ------------------------------------------------------------------
    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [7:0]        value;
        logic              last;
        logic [1:0]        idx;
        int                n_typed;   // -1: take the shadow's answer
        t_result [2:0]     r;
    } t_row;

    t_row dir_rows [$];

    function automatic void add_typed(input logic [7:0] b, input logic last, input int n,
                                      input t_result r0 = '0, input t_result r1 = '0,
                                      input t_result r2 = '0);
        t_row row;
        row.kind    = ROW_ITEM;
        row.value   = b;
        row.last    = last;
        row.idx     = REG_SEQ_TABS;
        row.n_typed = n;
        row.r[0]    = r0;
        row.r[1]    = r1;
        row.r[2]    = r2;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_item(input logic [7:0] b, input logic last);
        add_typed(b, last, -1);
    endfunction

    function automatic void add_reg(input logic [1:0] idx, input logic [7:0] val);
        t_row row;
        row.kind    = ROW_REG;
        row.value   = val;
        row.last    = 1'b0;
        row.idx     = idx;
        row.n_typed = -1;
        row.r       = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic void build_directed();
        // reset settings: header lines skipped, extreme byte in the name
        add_typed(HEADER_MARK_RST, 1'b0, 0);
        add_typed(8'hFF, 1'b0, 0);
        add_typed(NL_BYTE, 1'b0, 0);
        add_typed(8'h00, 1'b0, 2, data_res(RECORD_MARK_RST, 1'b0, 1'b0),
                  data_res(8'h00, 1'b1, 1'b0));
        add_typed(TAB_BYTE, 1'b0, 1, data_res(NL_BYTE, 1'b1, 1'b0));
        // newline while counting tabs ends the record silently
        add_typed(NL_BYTE, 1'b0, 0);
        // header mark after a record starts an ordinary record
        add_typed(HEADER_MARK_RST, 1'b0, 3, data_res(NL_BYTE, 1'b0, 1'b0),
                  data_res(RECORD_MARK_RST, 1'b0, 1'b0),
                  data_res(HEADER_MARK_RST, 1'b1, 1'b0));
        add_typed(NL_BYTE, 1'b0, 0);
        // empty line is a record with an empty name
        add_typed(NL_BYTE, 1'b0, 2, data_res(NL_BYTE, 1'b0, 1'b0),
                  data_res(RECORD_MARK_RST, 1'b1, 1'b0));
        // shortest tab count: sequence right after the name
        add_reg(REG_SEQ_TABS, 8'd1);
        add_item("A", 1'b0);
        add_item(TAB_BYTE, 1'b0);
        add_item("C", 1'b0);
        add_item(TAB_BYTE, 1'b0);
        add_item("x", 1'b0);
        add_typed(NL_BYTE, 1'b1, 1, END_MARK);
        // header mark equal to newline; a file without records
        add_reg(REG_HEADER_MARK, NL_BYTE);
        add_item(NL_BYTE, 1'b0);
        add_typed(NL_BYTE, 1'b1, 1, END_MARK);
        // tab count of zero behaves as one; all-ones record mark
        add_reg(REG_RECORD_MARK, 8'hFF);
        add_reg(REG_SEQ_TABS, 8'd0);
        add_item(TAB_BYTE, 1'b0);
        add_item("G", 1'b0);
        add_typed(8'hFF, 1'b1, 1, data_res(8'hFF, 1'b1, 1'b1));
        // widest tab count, all-zeros header mark
        add_reg(REG_SEQ_TABS, 8'd15);
        add_reg(REG_HEADER_MARK, 8'h00);
        add_item(8'h00, 1'b0);
        add_item(NL_BYTE, 1'b0);
        add_item("q", 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    int rx_stall = 0;

    // Present one byte, hold it until taken, book the owed items
    task automatic send_item(input logic [7:0] b, input logic last, input int n_typed,
                             input t_result [2:0] typed, input int gap);
        int n;
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= last;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        n = convert_byte(b, last);
        if (n_typed < 0) begin
            for (int i = 0; i < n; i++)
                fasta_q.push_back(pred_res[i]);
        end else begin
            for (int i = 0; i < n_typed; i++)
                fasta_q.push_back(typed[i]);
        end
        items_sent++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending and let every owed item come out, plus a little slack
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (fasta_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register and drop the valid again before returning
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        case (idx)
            REG_SEQ_TABS:    cfg_s.seq_field_tabs = val[3:0];
            REG_HEADER_MARK: cfg_s.header_mark    = val;
            REG_RECORD_MARK: cfg_s.record_mark    = val;
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Random SAM files
    // ------------------------------------------------------------------
    logic [7:0] fbytes [$];

    // One record line: name, filler fields, sequence, optional tail, newline.
    // Now and then one byte is overwritten with a separator or junk.
    function automatic void append_record();
        int start;
        int nt;
        int pos;
        start = fbytes.size();
        nt = (cfg_s.seq_field_tabs == 4'd0) ? 1 : int'(cfg_s.seq_field_tabs);
        repeat ($urandom_range(0, 3)) fbytes.push_back(text_byte());
        repeat (nt - 1) begin
            fbytes.push_back(TAB_BYTE);
            repeat ($urandom_range(0, 2)) fbytes.push_back(text_byte());
        end
        fbytes.push_back(TAB_BYTE);
        repeat ($urandom_range(0, 5)) fbytes.push_back(base_byte());
        if ($urandom_range(0, 1)) begin
            fbytes.push_back(TAB_BYTE);
            repeat ($urandom_range(0, 3)) fbytes.push_back(text_byte());
        end
        fbytes.push_back(NL_BYTE);
        if ($urandom_range(0, 5) == 0) begin
            pos = $urandom_range(start, fbytes.size() - 1);
            fbytes[pos] = noise_byte();
        end
    endfunction

    function automatic void build_file();
        fbytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            // pure noise
            repeat ($urandom_range(3, 12)) fbytes.push_back(noise_byte());
        end else begin
            repeat ($urandom_range(0, 2)) begin
                fbytes.push_back(cfg_s.header_mark);
                if (cfg_s.header_mark != NL_BYTE) begin
                    repeat ($urandom_range(0, 4)) fbytes.push_back(text_byte());
                    fbytes.push_back(NL_BYTE);
                end
            end
            repeat ($urandom_range(1, 3)) append_record();
            // drop the closing newline half the time
            if (fbytes.size() > 1 && $urandom_range(0, 1))
                void'(fbytes.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: random backpressure and the item checker
    // ------------------------------------------------------------------
    t_result got;
    t_result want;

    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0)
            rx_burst = !rx_burst;
        if (rx_stall > 0) begin
            rx_stall--;
            out_ch.ready <= 1'b0;
        end else if (rx_burst) begin
            out_ch.ready <= 1'b1;
        end else begin
            rx_stall = idle_len();
            if (rx_stall > 0) begin
                rx_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_byte: out_ch.out_byte, has_byte: out_ch.has_byte,
                    run_last: out_ch.run_last, stream_end: out_ch.stream_end};
            if (fasta_q.size() == 0) begin
                $display("%0t: item with nothing owed: byte %h has %b run_last %b end %b",
                         $time, got.out_byte, got.has_byte, got.run_last, got.stream_end);
                errors++;
            end else begin
                want = fasta_q.pop_front();
                checked++;
                if (got !== want) begin
                    $display("%0t: mismatch expected byte %h has %b run_last %b end %b",
                             $time, want.out_byte, want.has_byte, want.run_last,
                             want.stream_end);
                    $display("%0t:          actual   byte %h has %b run_last %b end %b",
                             $time, got.out_byte, got.has_byte, got.run_last,
                             got.stream_end);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_row row;
        int   rand_items;
        int   sel;
        logic [7:0] tabs_v;
        logic [7:0] hdr_v;
        logic [7:0] rec_v;

        // known values on every input from time zero
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = REG_SEQ_TABS;
        cfg_ch.data   = 8'h00;
        out_ch.ready  = 1'b0;
        cfg_s = '{seq_field_tabs: SEQ_TABS_RST, header_mark: HEADER_MARK_RST,
                  record_mark: RECORD_MARK_RST};
        clear_parse();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table
        build_directed();
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_REG) begin
                drain();
                write_reg(row.idx, row.value);
                settings++;
            end else begin
                send_item(row.value, row.last, row.n_typed, row.r, idle_len());
            end
        end
        files_sent += 4;

        // random phases: hold off until idle, pick new settings, stream files
        rand_items = 0;
        while (rand_items < 300) begin
            drain();
            sel = $urandom_range(0, 5);
            case (sel)
                0:       tabs_v = 8'd0;
                1:       tabs_v = 8'd1;
                2:       tabs_v = 8'd15;
                default: tabs_v = 8'($urandom_range(1, 4));
            endcase
            case ($urandom_range(0, 3))
                0:       hdr_v = HEADER_MARK_RST;
                1:       hdr_v = NL_BYTE;
                default: hdr_v = 8'($urandom_range(0, 255));
            endcase
            rec_v = $urandom_range(0, 1) ? RECORD_MARK_RST : 8'($urandom_range(0, 255));
            write_reg(REG_SEQ_TABS, tabs_v);
            write_reg(REG_HEADER_MARK, hdr_v);
            write_reg(REG_RECORD_MARK, rec_v);
            settings++;

            repeat ($urandom_range(2, 5)) begin
                if (rand_items >= 300)
                    break;
                tx_burst = ($urandom_range(0, 4) == 0);
                build_file();
                foreach (fbytes[j])
                    send_item(fbytes[j], j == fbytes.size() - 1, -1, '0,
                              tx_burst ? 0 : idle_len());
                rand_items += fbytes.size();
                files_sent++;
            end
        end

        // wind down: everything owed must come out, then nothing more
        in_ch.valid <= 1'b0;
        while (fasta_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d SAM bytes in %0d files over %0d register settings,",
                 items_sent, files_sent, settings);
        $display("with %0d FASTA items compared and %0d mismatches.", checked, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #1000000;
        $display("Timeout with %0d items still owed", fasta_q.size());
        $display("FAILURE");
        $finish;
    end

endmodule
